FILE: hdl/fpi_pkg.sv
// fpi_pkg: shared types, constants and helpers for the fasta pack and index unit
// no dependencies; compiled first
package fpi_pkg;

  localparam int WI_W  = 25;
  localparam int IDX_W = 24;
  localparam int SEQ_W = 32;

  localparam logic [WI_W-1:0] BUFFER_BYTES = 25'd16777216;

  localparam logic [7:0] CHAR_GT     = 8'h3E;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] DELIM_RESET = 8'h24;

  // configuration register indexes
  localparam logic [0:0] CFG_DELIMITER = 1'b0;
  localparam logic [0:0] CFG_FIRST_SEQ = 1'b1;

  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
  // the parse stage can hold one byte worth two words while another is taken
  localparam logic [FIFO_CW-1:0] ACCEPT_LIMIT = FIFO_CW'(FIFO_DEPTH - 4);

  typedef enum logic [1:0] {
    MODE_FIRST,
    MODE_START,
    MODE_HEADER,
    MODE_DATA
  } parse_mode_t;

  typedef enum logic [1:0] {
    SLOT_NONE,
    SLOT_BYTE,
    SLOT_MARK,
    SLOT_RECORD
  } slot_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic             byte_valid;
    logic [7:0]       out_byte;
    logic [WI_W-1:0]  write_offset;
    logic             record_valid;
    logic [SEQ_W-1:0] sequence_number;
    logic [IDX_W-1:0] record_start;
    logic [IDX_W-1:0] name_length;
    logic [IDX_W-1:0] data_length;
    logic             format_error;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [7:0]       delimiter;
    logic [SEQ_W-1:0] first_sequence_number;
  } cfg_t;

  // up to two result words produced by one parsed byte
  typedef struct packed {
    logic [1:0] count;
    result_t    item0;
    result_t    item1;
  } push_t;

  function automatic logic [WI_W-1:0] sat_inc(input logic [WI_W-1:0] x);
    logic [WI_W-1:0] r;
    r = (x < BUFFER_BYTES) ? x + WI_W'(1) : x;
    return r;
  endfunction

endpackage

FILE: hdl/fpi_channels.sv
// fpi_in_if / fpi_out_if: valid-ready channels for input bytes and result words
// depends on fpi_pkg
interface fpi_in_if import fpi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fpi_out_if import fpi_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/fpi_parser.sv
// fpi_parser: input register, parse state and per-byte result generation
// depends on fpi_pkg and fpi_channels
module fpi_parser import fpi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fpi_in_if.sink     in_ch,
  input  logic       room,
  input  cfg_t       cfg,
  output push_t      push
);

  logic             stage_valid;
  in_item_t         stage;

  parse_mode_t      mode, mode_next;
  logic             pending, pending_next;
  logic             halted, halted_next;
  logic [WI_W-1:0]  write_index, write_index_next;
  logic [IDX_W-1:0] header_start, header_start_next;
  logic [IDX_W-1:0] mark_position, mark_position_next;
  logic [SEQ_W-1:0] next_number, next_number_next;

  logic             accept;
  logic             is_gt, is_nl, first, go, bad, close, lst;
  parse_mode_t      mode_e;
  logic             pend_e;
  logic [WI_W-1:0]  wi_e, pos0, pos1;
  logic [IDX_W-1:0] hs_e, mp_e;
  logic [SEQ_W-1:0] nn_e;
  slot_kind_t       slot0, slot1;
  result_t          err_item;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
    if (accept) begin
      stage <= in_ch.data;
    end
  end

  // shared decode
  assign is_gt  = (stage.in_byte == CHAR_GT);
  assign is_nl  = (stage.in_byte == CHAR_NL);
  assign lst    = stage.is_last;
  assign first  = (mode == MODE_FIRST);
  assign go     = stage_valid && !halted;
  assign bad    = go && first && !is_gt;
  assign mode_e = first ? MODE_START : mode;
  assign pend_e = pending && !first;
  assign close  = pend_e && is_gt;

  // a new buffer restarts offsets and numbering
  assign wi_e = first ? '0 : write_index;
  assign hs_e = first ? '0 : header_start;
  assign mp_e = first ? '0 : mark_position;
  assign nn_e = first ? cfg.first_sequence_number : next_number;
  assign pos0 = wi_e;
  assign pos1 = sat_inc(pos0);

  // next state
  always_comb begin
    mode_next    = mode;
    pending_next = pending;
    halted_next  = halted;
    if (bad) begin
      halted_next = 1'b1;
    end else if (go) begin
      pending_next = 1'b0;
      case (mode_e)
        MODE_START: begin
          if (is_gt) begin
            mode_next = MODE_HEADER;
          end else if (is_nl) begin
            mode_next    = MODE_START;
            pending_next = !lst;
          end else begin
            mode_next = MODE_DATA;
          end
        end
        MODE_HEADER: begin
          if (is_nl) begin
            mode_next = MODE_START;
          end
        end
        MODE_DATA: begin
          if (is_nl) begin
            mode_next    = MODE_START;
            pending_next = !lst;
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
      if (lst) begin
        mode_next    = MODE_FIRST;
        pending_next = 1'b0;
      end
    end
  end

  // result slots
  always_comb begin
    slot0 = SLOT_NONE;
    slot1 = SLOT_NONE;
    if (go && !bad) begin
      case (mode_e)
        MODE_START: begin
          if (is_gt) begin
            if (close) begin
              slot0 = SLOT_RECORD;
              slot1 = SLOT_BYTE;
            end else begin
              slot0 = SLOT_BYTE;
              if (lst) slot1 = SLOT_MARK;
            end
          end else if (is_nl) begin
            if (lst) slot0 = SLOT_RECORD;
          end else begin
            slot0 = SLOT_BYTE;
            if (lst) slot1 = SLOT_RECORD;
          end
        end
        MODE_HEADER: begin
          slot0 = is_nl ? SLOT_MARK : SLOT_BYTE;
          if (lst && !is_nl) slot1 = SLOT_MARK;
        end
        MODE_DATA: begin
          if (is_nl) begin
            if (lst) slot0 = SLOT_RECORD;
          end else begin
            slot0 = SLOT_BYTE;
            if (lst) slot1 = SLOT_RECORD;
          end
        end
        default: begin
          slot0 = SLOT_NONE;
        end
      endcase
    end
  end

  // index registers
  always_comb begin
    write_index_next   = write_index;
    header_start_next  = header_start;
    mark_position_next = mark_position;
    next_number_next   = next_number;
    if (go && !bad) begin
      header_start_next  = hs_e;
      mark_position_next = mp_e;
      next_number_next   = nn_e;
      if (mode_e == MODE_START && is_gt) begin
        header_start_next = close ? pos1[IDX_W-1:0] : pos0[IDX_W-1:0];
      end
      if (slot0 == SLOT_MARK) mark_position_next = pos0[IDX_W-1:0];
      if (slot1 == SLOT_MARK) mark_position_next = pos1[IDX_W-1:0];
      if (slot0 == SLOT_RECORD || slot1 == SLOT_RECORD) begin
        next_number_next = nn_e + SEQ_W'(1);
      end
      if (slot1 != SLOT_NONE) begin
        write_index_next = sat_inc(pos1);
      end else if (slot0 != SLOT_NONE) begin
        write_index_next = pos1;
      end else begin
        write_index_next = pos0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_FIRST;
      pending       <= 1'b0;
      halted        <= 1'b0;
      write_index   <= '0;
      header_start  <= '0;
      mark_position <= '0;
      next_number   <= '0;
    end else begin
      mode          <= mode_next;
      pending       <= pending_next;
      halted        <= halted_next;
      write_index   <= write_index_next;
      header_start  <= header_start_next;
      mark_position <= mark_position_next;
      next_number   <= next_number_next;
    end
  end

  function automatic result_t build(input slot_kind_t kind, input logic [WI_W-1:0] pos,
                                    input logic fin);
    result_t r;
    r = '0;
    r.byte_valid   = 1'b1;
    r.write_offset = pos;
    r.last         = fin;
    case (kind)
      SLOT_BYTE: begin
        r.out_byte = stage.in_byte;
      end
      SLOT_MARK: begin
        r.out_byte = CHAR_HASH;
      end
      SLOT_RECORD: begin
        r.out_byte        = cfg.delimiter;
        r.record_valid    = 1'b1;
        r.sequence_number = nn_e;
        r.record_start    = hs_e;
        r.name_length     = mp_e - hs_e;
        r.data_length     = pos[IDX_W-1:0] - mp_e;
      end
      default: begin
        r.byte_valid = 1'b0;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    err_item              = '0;
    err_item.format_error = 1'b1;
    err_item.last         = 1'b1;
  end

  always_comb begin
    push.item0 = build(slot0, pos0, slot1 == SLOT_NONE);
    push.item1 = build(slot1, pos1, 1'b1);
    push.count = {1'b0, slot0 != SLOT_NONE} + {1'b0, slot1 != SLOT_NONE};
    if (bad) begin
      push.item0 = err_item;
      push.count = 2'd1;
    end
  end

endmodule

FILE: hdl/fpi_result_fifo.sv
// fpi_result_fifo: result queue taking up to two words a cycle, one out a cycle
// depends on fpi_pkg and fpi_channels
module fpi_result_fifo import fpi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  fpi_out_if.source  out_ch,
  output logic       room
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 pop;

  assign out_ch.valid = (count != '0);
  assign out_ch.data  = mem[rd_ptr];
  assign pop          = out_ch.valid && out_ch.ready;
  assign room         = (count <= ACCEPT_LIMIT);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.item0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end
  end

endmodule

FILE: hdl/fasta_pack_and_index_unit.sv
// fasta_pack_and_index_unit: packs a FASTA byte stream and emits record index words
// depends on fpi_pkg, fpi_channels, fpi_parser and fpi_result_fifo
// latency: a result word is registered in the input stage and then in the result queue before it is offered
// throughput: one byte per cycle; a byte that yields two words puts both into the queue, which offers
// one word at a time; input stalls while the 8-entry result queue holds more than 4 words
// reset: synchronous rst clears parse state and the queue; delimiter returns to '$'
module fasta_pack_and_index_unit import fpi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  fpi_in_if.sink      in_ch,
  fpi_out_if.source   out_ch,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t  cfg;
  push_t push;
  logic  room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter             <= DELIM_RESET;
      cfg.first_sequence_number <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DELIMITER: cfg.delimiter             <= cfg_data[7:0];
        CFG_FIRST_SEQ: cfg.first_sequence_number <= cfg_data[SEQ_W-1:0];
        default:       cfg.delimiter             <= cfg.delimiter;
      endcase
    end
  end

  fpi_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .room  (room),
    .cfg   (cfg),
    .push  (push)
  );

  fpi_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .out_ch (out_ch),
    .room   (room)
  );

endmodule

FILE: tb/tb.sv
// tb: self-checking bench for fasta_pack_and_index_unit; predicts each packed word and
// record index in step with accepted bytes and compares them as words leave the block
// depends on fpi_pkg, fpi_channels and the unit's rtl
module tb import fpi_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 360;
  localparam int RUN_LIMIT_NS  = 8000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;

  fpi_in_if  in_ch ();
  fpi_out_if out_ch ();

  fasta_pack_and_index_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // predictor state, mirrors the block
  parse_mode_t      pmode       = MODE_FIRST;
  bit               nl_held     = 1'b0;
  bit               stopped     = 1'b0;
  logic [WI_W-1:0]  pack_pos    = '0;
  logic [IDX_W-1:0] hdr_start   = '0;
  logic [IDX_W-1:0] mark_pos    = '0;
  logic [SEQ_W-1:0] seq_next    = '0;
  logic [7:0]       delim_reg   = DELIM_RESET;
  logic [31:0]      first_seq   = '0;

  result_t    words_due[$];
  logic [7:0] fasta_text[$];
  int         mismatches    = 0;
  int         bytes_sent    = 0;
  bit         src_idle_on   = 1'b1;
  bit         snk_idle_on   = 1'b1;
  bit         hold_request  = 1'b0;

  function automatic int idle_gap(bit on);
    return on ? int'($urandom_range(0, 11)) : 0;
  endfunction

  function automatic void emit_packed(logic [7:0] b);
    result_t r;
    r = '0;
    r.byte_valid   = 1'b1;
    r.out_byte     = b;
    r.write_offset = pack_pos;
    words_due.push_back(r);
    if (pack_pos < BUFFER_BYTES) pack_pos++;
  endfunction

  function automatic void close_record();
    result_t r;
    r = '0;
    r.byte_valid      = 1'b1;
    r.out_byte        = delim_reg;
    r.write_offset    = pack_pos;
    r.record_valid    = 1'b1;
    r.sequence_number = seq_next;
    r.record_start    = hdr_start;
    r.name_length     = mark_pos - hdr_start;
    r.data_length     = pack_pos[IDX_W-1:0] - mark_pos;
    words_due.push_back(r);
    seq_next++;
    if (pack_pos < BUFFER_BYTES) pack_pos++;
  endfunction

  // expected words caused by one accepted byte
  function automatic void pack_and_index(logic [7:0] b, bit eob);
    result_t r;
    int      n0;
    bit      closed;
    closed = 1'b0;
    if (stopped) return;
    if (pmode == MODE_FIRST) begin
      if (b != CHAR_GT) begin
        r = '0;
        r.format_error = 1'b1;
        r.last         = 1'b1;
        words_due.push_back(r);
        stopped = 1'b1;
        return;
      end
      pack_pos  = '0;
      hdr_start = '0;
      mark_pos  = '0;
      seq_next  = first_seq;
      nl_held   = 1'b0;
      pmode     = MODE_START;
    end
    n0 = words_due.size();
    // a held newline becomes the delimiter only when a header follows
    if (nl_held) begin
      nl_held = 1'b0;
      if (b == CHAR_GT) begin
        close_record();
        closed = 1'b1;
      end
    end
    case (pmode)
      MODE_START: begin
        if (b == CHAR_GT) begin
          hdr_start = pack_pos[IDX_W-1:0];
          emit_packed(b);
          pmode = MODE_HEADER;
          // lone header at the end: mark dropped if a record already closed here
          if (eob && !closed) begin
            mark_pos = pack_pos[IDX_W-1:0];
            emit_packed(CHAR_HASH);
          end
        end else if (b == CHAR_NL) begin
          if (eob) close_record();
          else nl_held = 1'b1;
        end else begin
          pmode = MODE_DATA;
          emit_packed(b);
          if (eob) close_record();
        end
      end
      MODE_HEADER: begin
        if (b == CHAR_NL) begin
          mark_pos = pack_pos[IDX_W-1:0];
          emit_packed(CHAR_HASH);
          pmode = MODE_START;
        end else begin
          emit_packed(b);
          if (eob) begin
            mark_pos = pack_pos[IDX_W-1:0];
            emit_packed(CHAR_HASH);
          end
        end
      end
      default: begin
        if (b == CHAR_NL) begin
          if (eob) close_record();
          else nl_held = 1'b1;
          pmode = MODE_START;
        end else begin
          emit_packed(b);
          if (eob) close_record();
        end
      end
    endcase
    if (eob) begin
      pmode   = MODE_FIRST;
      nl_held = 1'b0;
    end
    if (words_due.size() > n0) words_due[words_due.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : word_checker
    result_t want;
    result_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (words_due.size() == 0) begin
        mismatches++;
        $display("%0t unexpected word: expected none, actual %h", $time, got);
      end else begin
        want = words_due.pop_front();
        check_field("byte_valid", want.byte_valid, got.byte_valid);
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("write_offset", want.write_offset, got.write_offset);
        check_field("record_valid", want.record_valid, got.record_valid);
        check_field("sequence_number", want.sequence_number, got.sequence_number);
        check_field("record_start", want.record_start, got.record_start);
        check_field("name_length", want.name_length, got.name_length);
        check_field("data_length", want.data_length, got.data_length);
        check_field("format_error", want.format_error, got.format_error);
        check_field("last", want.last, got.last);
      end
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin : word_sink
    int gap;
    out_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        gap = idle_gap(snk_idle_on);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eob);
    int gap;
    gap = idle_gap(src_idle_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{in_byte: b, is_last: eob};
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pack_and_index(b, eob);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (fasta_text[i]) send_byte(fasta_text[i], i == fasta_text.size() - 1);
    fasta_text.delete();
  endtask

  task automatic drain_words();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (words_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    // bytes that give no word may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == CFG_DELIMITER) delim_reg = value[7:0];
    else first_seq = value;
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) fasta_text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (v == CHAR_NL) v = 8'h41;
    return v;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return CHAR_NL;
      1: return CHAR_GT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // style 0 well formed, 1 cut header, 2 no final newline, 3 noise tail
  function automatic void build_fasta(int nrec, int style);
    for (int r = 0; r < nrec; r++) begin
      fasta_text.push_back(CHAR_GT);
      repeat ($urandom_range(0, 8)) fasta_text.push_back(text_byte());
      fasta_text.push_back(CHAR_NL);
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(0, 12)) fasta_text.push_back(text_byte());
        fasta_text.push_back(CHAR_NL);
      end
    end
    case (style)
      1: begin
        fasta_text.push_back(CHAR_GT);
        repeat ($urandom_range(0, 6)) fasta_text.push_back(text_byte());
      end
      2: void'(fasta_text.pop_back());
      3: repeat ($urandom_range(5, 40)) fasta_text.push_back(noise_byte());
      default: ;
    endcase
  endfunction

  task automatic test_directed_cases();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    // byte extremes, '>' inside a data line, blank line, empty name, header after header
    put_str(">a\n");
    fasta_text.push_back(8'h00);
    fasta_text.push_back(8'hFF);
    put_str(">\n\n>\n>b");
    send_buffer();
    // lone '>' at the end right after a record closes
    put_str(">\nA\n>");
    send_buffer();
    // missing final newline
    put_str(">\nC");
    send_buffer();
    put_str(">x\nG\n");
    send_buffer();
    drain_words();
  endtask

  task automatic test_register_extremes();
    logic [7:0]  delims[4] = '{8'h00, 8'hFF, CHAR_NL, CHAR_GT};
    logic [31:0] seqs[4]   = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'hFFFF_FFFE};
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_DELIMITER, {24'h0, delims[p]});
      write_reg(CFG_FIRST_SEQ, seqs[p]);
      src_idle_on = p[0];
      snk_idle_on = p[1];
      build_fasta(3, p % 3);
      send_buffer();
      drain_words();
    end
    write_reg(CFG_DELIMITER, {24'h0, DELIM_RESET});
    write_reg(CFG_FIRST_SEQ, 32'h0);
  endtask

  task automatic test_random_buffers();
    int start;
    int style;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        drain_words();
        write_reg(CFG_DELIMITER, $urandom_range(0, 255));
        write_reg(CFG_FIRST_SEQ, $urandom);
      end
      style = $urandom_range(0, 9);
      build_fasta($urandom_range(1, 4), (style < 6) ? 0 : style - 6);
      send_buffer();
    end
    drain_words();
  endtask

  task automatic test_output_stall();
    src_idle_on  = 1'b0;
    snk_idle_on  = 1'b0;
    hold_request = 1'b1;
    while (fasta_text.size() < 80) build_fasta(2, 0);
    send_buffer();
    drain_words();
  endtask

  // must run last: the block stays halted until reset
  task automatic test_bad_first_byte();
    logic [7:0] bad;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    bad = 8'($urandom_range(0, 254));
    if (bad >= CHAR_GT) bad++;
    send_byte(bad, 1'b0);
    put_str(">q\nAC\n");
    send_buffer();
    put_str(">r\nT");
    send_buffer();
    drain_words();
  endtask

  initial begin : run_tests
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_write   = 1'b0;
    cfg_index   = CFG_DELIMITER;
    cfg_data    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_register_extremes();
    test_random_buffers();
    test_output_stall();
    test_bad_first_byte();
    drain_words();
    if (words_due.size() != 0)
      $display("%0t missing words: expected %h, actual none (%0d outstanding)",
               $time, words_due[0], words_due.size());
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: fasta_pack_and_index_unit.f
hdl/fpi_pkg.sv
hdl/fpi_channels.sv
hdl/fpi_parser.sv
hdl/fpi_result_fifo.sv
hdl/fasta_pack_and_index_unit.sv
tb/tb.sv
